### hw/rtl/ird_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the input-restricted deque unit.
// ----------------------------------------------------------------------------
package ird_pkg;

  // Storage geometry
  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_INSERT   = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_REM_TAIL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    clr;
    logic    wr;
    logic    rd;
    logic    rd_tail;
    logic    head_inc;
    logic    tail_inc;
    logic    tail_dec;
    logic    st_load;
    status_t st_code;
  } ird_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    op_t  op;
  } ird_stat_t;

endpackage

### hw/rtl/ird_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ird_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ird_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_ctrl
// Controller: sequences accept, execute and respond for each beat.
// ----------------------------------------------------------------------------
module ird_ctrl import ird_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ird_stat_t stat,
  output ird_cmd_t  cmd,
  output logic      busy,
  output logic      emit
);

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decide next state and issue datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_OK;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.st_load = 1'b1;
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          OP_INSERT: begin
            if (stat.full) begin
              cmd.st_code = ST_OVERFLOW;
            end else begin
              cmd.wr       = 1'b1;
              cmd.tail_inc = 1'b1;
            end
          end
          OP_REM_HEAD: begin
            if (stat.empty) begin
              cmd.st_code = ST_UNDERFLOW;
            end else begin
              cmd.rd       = 1'b1;
              cmd.head_inc = 1'b1;
            end
          end
          OP_REM_TAIL: begin
            if (stat.empty) begin
              cmd.st_code = ST_UNDERFLOW;
            end else begin
              cmd.rd       = 1'b1;
              cmd.rd_tail  = 1'b1;
              cmd.tail_dec = 1'b1;
            end
          end
          default: begin
            cmd.st_code = ST_OK;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/ird_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_dpath
// Datapath: indices, entry storage, latched beat and result registers.
// ----------------------------------------------------------------------------
module ird_dpath import ird_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ird_cmd_t                 cmd,
  input  logic [1:0]               in_operation,
  input  logic signed [DATA_W-1:0] in_data_in,
  output ird_stat_t                stat,
  output logic signed [DATA_W-1:0] data_out,
  output logic [1:0]               status
);

  op_t               op_r;
  logic [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  status_t           st_r;
  logic              rd_ok_r;
  logic [IDX_W-1:0]  tail_m1;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  // Latch the incoming beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      data_r <= in_data_in;
    end
  end

  // Advance head and tail
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.clr) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (cmd.head_inc) head_nxt = head_r + IDX_W'(1);
      if (cmd.tail_inc) tail_nxt = tail_r + IDX_W'(1);
      if (cmd.tail_dec) tail_nxt = tail_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Hold the result status for the response cycle
  always_ff @(posedge clk) begin
    if (cmd.st_load) begin
      st_r    <= cmd.st_code;
      rd_ok_r <= cmd.rd;
    end
  end

  assign tail_m1 = tail_r - IDX_W'(1);
  assign raddr   = cmd.rd_tail ? tail_m1[ADDR_W-1:0] : head_r[ADDR_W-1:0];

  ird_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (tail_r[ADDR_W-1:0]),
    .wdata (data_r),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Report occupancy to the controller
  assign stat.full  = (tail_r == IDX_FULL);
  assign stat.empty = (head_r == tail_r);
  assign stat.op    = op_r;

  // Drop data to zero unless a removal succeeded
  assign data_out = rd_ok_r ? $signed(rdata) : '0;
  assign status   = st_r;

endmodule

### hw/rtl/input_restricted_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_restricted_deque_unit
// Input-restricted deque in a linear array: clear, insert at tail,
// remove from head, remove from tail; one result beat per command.
// ----------------------------------------------------------------------------
// Sequencing: the accepting edge moves the controller to execute, where the RAM
//   read is issued; out_valid is driven in the respond state that follows it.
// Command flow: a new command is accepted only back in idle, after the accept,
//   execute and respond steps of the last one, set by the controller sequence.
// The receiver cannot stall; out_valid is high for exactly one cycle.
// Reset (rst_n low, synchronous) empties the deque; entries stay unwritten.
module input_restricted_deque_unit import ird_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [1:0]               out_status
);

  ird_cmd_t  cmd;
  ird_stat_t stat;

  ird_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .emit  (out_valid)
  );

  ird_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_data_in   (in_data_in),
    .stat         (stat),
    .data_out     (out_data_out),
    .status       (out_status)
  );

  // Check sequencing and result coding
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |-> (out_data_out == '0))
    else $error("underflow result carried nonzero data");

endmodule
